FILE: src/svge_pkg.sv
// Package with shared constants, types and arithmetic helpers of the gate engine.
`timescale 1ns / 1ps
package svge_pkg;
    localparam int MaxQubits = 10;
    localparam int FracBits  = 16;
    localparam int CompW     = FracBits + 2;
    localparam int Depth     = 1 << MaxQubits;
    localparam int AddrW     = MaxQubits;
    localparam int QW        = 4;

    localparam logic [3:0] FUNC_H     = 4'd0;
    localparam logic [3:0] FUNC_X     = 4'd1;
    localparam logic [3:0] FUNC_Y     = 4'd2;
    localparam logic [3:0] FUNC_Z     = 4'd3;
    localparam logic [3:0] FUNC_RX    = 4'd4;
    localparam logic [3:0] FUNC_RY    = 4'd5;
    localparam logic [3:0] FUNC_RZ    = 4'd6;
    localparam logic [3:0] FUNC_CNOT  = 4'd7;
    localparam logic [3:0] FUNC_CZ    = 4'd8;
    localparam logic [3:0] FUNC_READ  = 4'd9;
    localparam logic [3:0] FUNC_GND   = 4'd10;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FUNC  = 2'd2;

    // sqrt(1/2) rounded to FracBits fraction bits.
    localparam longint SqrtHalfQ32 = 64'd3037000500;
    localparam logic [CompW-1:0] HalfRoot =
        CompW'((SqrtHalfQ32 + (64'd1 << (31 - FracBits))) >> (32 - FracBits));
    localparam logic signed [CompW-1:0] One = CompW'(1 << FracBits);
    localparam logic signed [CompW-1:0] CompMax = CompW'((1 << (FracBits + 1)) - 1);
    localparam logic signed [CompW-1:0] CompMin = CompW'(-(1 << (FracBits + 1)));

    localparam int ProdW = 2 * CompW + 2;
    localparam int AccW  = 2 * CompW + MaxQubits + 2;

    typedef logic signed [CompW-1:0] t_comp;

    typedef struct packed {
        logic [3:0]     func;
        logic [QW-1:0]  tq;
        logic [QW-1:0]  cq;
        logic [AddrW:0] dim;
    } t_cmd;

    typedef struct packed {
        logic       start_gate;
        logic       start_z;
        logic       start_read;
        logic       start_gnd;
    } t_ctl;

    typedef struct packed {
        logic busy;
    } t_sts;

    function automatic t_comp sat_comp(input logic signed [AccW-1:0] x);
        if (x > AccW'(CompMax)) return CompMax;
        if (x < AccW'(CompMin)) return CompMin;
        return x[CompW-1:0];
    endfunction

    // Round to nearest with half toward plus infinity, then saturate.
    function automatic t_comp rnd(input logic signed [ProdW-1:0] x);
        logic signed [ProdW-1:0] y;
        y = (x + ProdW'(1 << (FracBits - 1))) >>> FracBits;
        return sat_comp(AccW'(y));
    endfunction
endpackage

FILE: src/svge_ctrl.sv
// Controller: request decode, error checks and sequencing of the datapath.
`timescale 1ns / 1ps
module svge_ctrl import svge_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [3:0]     i_func,
    input  logic [QW-1:0]  i_tq,
    input  logic [QW-1:0]  i_cq,
    input  logic [AddrW-1:0] i_idx,
    input  logic [3:0]     i_nq,
    input  logic           i_out_free,
    output t_ctl           o_ctl,
    output t_cmd           o_cmd,
    output logic           o_err,
    output logic [1:0]     o_err_code,
    input  t_sts           i_sts
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_GATE = 2'd1;
    localparam logic [1:0] S_Z    = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    logic [1:0] r_state, n_state;
    t_cmd       r_cmd, n_cmd;
    logic [3:0] nq;
    logic [AddrW:0] dim;
    logic [1:0] chk;

    always_comb begin
        nq = i_nq;
        if (nq < 4'd1) nq = 4'd1;
        if (nq > 4'(MaxQubits)) nq = 4'(MaxQubits);
        dim = (AddrW+1)'(1) << nq;
        chk = ST_OK;
        if (i_func > FUNC_GND) chk = ST_FUNC;
        else if (i_func <= FUNC_CZ && (i_tq >= nq ||
                 (i_func >= FUNC_CNOT && i_cq >= nq))) chk = ST_RANGE;
        else if (i_func == FUNC_READ && (AddrW+1)'(i_idx) >= dim) chk = ST_RANGE;
    end

    assign o_ready = (r_state == S_IDLE) && i_out_free;
    assign o_cmd = r_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd;
        o_ctl = '0;
        o_err = 1'b0;
        o_err_code = chk;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_cmd = '{func: i_func, tq: i_tq, cq: i_cq, dim: dim};
                    if (chk != ST_OK) begin
                        o_err = 1'b1;
                    end else if (i_func == FUNC_READ) begin
                        o_ctl.start_read = 1'b1;
                        n_state = S_Z;
                    end else if (i_func == FUNC_GND) begin
                        o_ctl.start_gnd = 1'b1;
                        n_state = S_GATE;
                    end else begin
                        o_ctl.start_gate = 1'b1;
                        n_state = S_GATE;
                    end
                end
            end
            S_GATE: begin
                if (!i_sts.busy) begin
                    o_ctl.start_z = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_Z: begin
                if (!i_sts.busy) begin
                    o_ctl.start_z = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!i_sts.busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
        r_cmd <= n_cmd;
    end
endmodule

FILE: src/svge_datapath.sv
// Datapath: amplitude memory, ground clear, pair sweep engine, read and Z expectation sweep.
`timescale 1ns / 1ps
module svge_datapath import svge_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_ctl           i_ctl,
    input  t_cmd           i_cmd,
    input  logic [AddrW-1:0] i_idx,
    input  t_comp          i_cos,
    input  t_comp          i_sin,
    output t_sts           o_sts,
    output logic           o_done,
    output t_comp          o_are,
    output t_comp          o_aim,
    output t_comp          o_meas,
    output t_comp          o_z
);
    // Operation of the sweep engine.
    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_CLR  = 3'd1;
    localparam logic [2:0] P_RDA  = 3'd2;
    localparam logic [2:0] P_RDB  = 3'd3;
    localparam logic [2:0] P_CALC = 3'd4;
    localparam logic [2:0] P_WRB  = 3'd5;
    localparam logic [2:0] P_ZRD  = 3'd6;
    localparam logic [2:0] P_RD1  = 3'd7;

    logic [2*CompW-1:0] mem [Depth];
    logic [2*CompW-1:0] r_rdata;
    logic [AddrW-1:0]   raddr, waddr;
    logic [2*CompW-1:0] wdata;
    logic               we;

    logic [2:0]     r_ph, n_ph;
    logic [AddrW:0] r_cnt, n_cnt;
    logic           r_zlast, r_zv;
    logic           r_ispair;
    logic           r_bv;
    t_comp r_ar, r_ai, r_br, r_bi;
    t_comp r_nar, r_nai, r_nbr, r_nbi;
    logic signed [AccW-1:0] r_acc;
    logic           r_rdq;
    logic           r_ztail;
    logic [AddrW-1:0] r_zidx;
    logic r_zsel, r_zneg, r_zlast_q;

    logic [AddrW-1:0] tmask, cmask, ia, ib;
    logic [AddrW-1:0] pidx;
    logic skip;

    assign tmask = AddrW'(1) << i_cmd.tq;
    assign cmask = AddrW'(1) << i_cmd.cq;

    // Insert a zero at the target bit to form the lower index of a pair.
    always_comb begin
        logic [AddrW-1:0] lo, c;
        c  = r_cnt[AddrW-1:0];
        lo = c & (tmask - AddrW'(1));
        ia = ((c & ~(tmask - AddrW'(1))) << 1) | lo;
        ib = ia | tmask;
    end

    always_comb begin
        pidx = ia;
        skip = 1'b0;
        if (i_cmd.func == FUNC_CNOT || i_cmd.func == FUNC_CZ) begin
            skip = (i_cmd.cq == i_cmd.tq) || ((ia & cmask) == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rdata <= mem[raddr];
    end

    // Products for the pair update, one multiply per term, registered after.
    logic signed [ProdW-1:0] m0, m1, m2, m3, m4, m5, m6, m7;
    logic signed [ProdW-1:0] r_m0, r_m1, r_m2, r_m3, r_m4, r_m5, r_m6, r_m7;
    logic                    r_mv;
    always_comb begin
        logic signed [CompW:0] sr, si, dr, di;
        sr = (CompW+1)'(r_ar) + (CompW+1)'(r_br);
        si = (CompW+1)'(r_ai) + (CompW+1)'(r_bi);
        dr = (CompW+1)'(r_ar) - (CompW+1)'(r_br);
        di = (CompW+1)'(r_ai) - (CompW+1)'(r_bi);
        m0 = ProdW'(sr) * ProdW'($signed({1'b0, HalfRoot}));
        m1 = ProdW'(si) * ProdW'($signed({1'b0, HalfRoot}));
        m2 = ProdW'(dr) * ProdW'($signed({1'b0, HalfRoot}));
        m3 = ProdW'(di) * ProdW'($signed({1'b0, HalfRoot}));
        m4 = '0; m5 = '0; m6 = '0; m7 = '0;
        case (i_cmd.func) inside
            FUNC_RX, FUNC_RY, FUNC_RZ: begin
                m0 = ProdW'(i_cos) * ProdW'(r_ar);
                m1 = ProdW'(i_cos) * ProdW'(r_ai);
                m2 = ProdW'(i_cos) * ProdW'(r_br);
                m3 = ProdW'(i_cos) * ProdW'(r_bi);
                m4 = ProdW'(i_sin) * ProdW'(r_ar);
                m5 = ProdW'(i_sin) * ProdW'(r_ai);
                m6 = ProdW'(i_sin) * ProdW'(r_br);
                m7 = ProdW'(i_sin) * ProdW'(r_bi);
            end
            default: ;
        endcase
    end

    function automatic t_comp neg(input t_comp v);
        return sat_comp(-AccW'(v));
    endfunction

    always_comb begin
        r_nar = r_ar; r_nai = r_ai; r_nbr = r_br; r_nbi = r_bi;
        case (i_cmd.func) inside
            FUNC_H: begin
                r_nar = rnd(r_m0); r_nai = rnd(r_m1);
                r_nbr = rnd(r_m2); r_nbi = rnd(r_m3);
            end
            FUNC_X, FUNC_CNOT: begin
                r_nar = r_br; r_nai = r_bi; r_nbr = r_ar; r_nbi = r_ai;
            end
            FUNC_Y: begin
                r_nar = r_bi; r_nai = neg(r_br); r_nbr = neg(r_ai); r_nbi = r_ar;
            end
            FUNC_Z, FUNC_CZ: begin
                r_nbr = neg(r_br); r_nbi = neg(r_bi);
            end
            FUNC_RX: begin
                r_nar = rnd(r_m0 + r_m7); r_nai = rnd(r_m1 - r_m6);
                r_nbr = rnd(r_m5 + r_m2); r_nbi = rnd(r_m3 - r_m4);
            end
            FUNC_RY: begin
                r_nar = rnd(r_m0 - r_m6); r_nai = rnd(r_m1 - r_m7);
                r_nbr = rnd(r_m4 + r_m2); r_nbi = rnd(r_m5 + r_m3);
            end
            FUNC_RZ: begin
                r_nbr = rnd(r_m2 - r_m7); r_nbi = rnd(r_m3 + r_m6);
            end
            default: ;
        endcase
    end

    // Probability of the word just read, squared and rounded.
    logic signed [CompW-1:0] pr, pi;
    logic [2*CompW-1:0] r_sq;
    logic               r_sqv;
    logic signed [AccW-1:0] prob;
    assign pr = r_rdata[CompW-1:0];
    assign pi = r_rdata[2*CompW-1:CompW];
    always_comb begin
        logic [AccW-1:0] u;
        u = AccW'(r_sq);
        u = (u + AccW'(1 << (FracBits - 1))) >> FracBits;
        prob = (u > AccW'(CompMax)) ? AccW'(CompMax) : $signed(u);
    end

    logic signed [2*CompW-1:0] sqr, sqi;
    assign sqr = (2*CompW)'(pr) * (2*CompW)'(pr);
    assign sqi = (2*CompW)'(pi) * (2*CompW)'(pi);

    assign o_sts.busy = (r_ph != P_IDLE) || r_zv || r_sqv || r_ztail || r_mv;

    always_comb begin
        n_ph = r_ph;
        n_cnt = r_cnt;
        raddr = ia;
        waddr = ia;
        wdata = {r_nai, r_nar};
        we = 1'b0;
        unique case (r_ph)
            P_IDLE: begin
                if (i_ctl.start_gnd) begin
                    n_ph = P_CLR; n_cnt = '0;
                end else if (i_ctl.start_gate) begin
                    n_ph = P_RDA; n_cnt = '0;
                end else if (i_ctl.start_read) begin
                    n_ph = P_RD1;
                end else if (i_ctl.start_z) begin
                    n_ph = P_ZRD; n_cnt = '0;
                end
            end
            P_CLR: begin
                we = 1'b1;
                waddr = r_cnt[AddrW-1:0];
                wdata = (r_cnt == '0) ? {t_comp'(0), One} : '0;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (AddrW+1)'(Depth - 1)) n_ph = P_IDLE;
            end
            P_RDA: begin
                if (r_cnt >= (i_cmd.dim >> 1)) n_ph = P_IDLE;
                else if (skip) n_cnt = r_cnt + 1'b1;
                else begin
                    raddr = ia; n_ph = P_RDB;
                end
            end
            P_RDB: begin
                raddr = ib; n_ph = P_CALC;
            end
            P_CALC: begin
                if (r_mv) begin
                    we = 1'b1; waddr = pidx; wdata = {r_nai, r_nar};
                    n_ph = P_WRB;
                end
            end
            P_WRB: begin
                we = 1'b1; waddr = ib; wdata = {r_nbi, r_nbr};
                n_cnt = r_cnt + 1'b1;
                n_ph = P_RDA;
            end
            P_ZRD: begin
                raddr = r_cnt[AddrW-1:0];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == i_cmd.dim - 1'b1) n_ph = P_IDLE;
            end
            P_RD1: begin
                raddr = i_idx;
                n_ph = P_IDLE;
            end
            default: n_ph = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= P_CLR;
            r_cnt <= '0;
            r_zv <= 1'b0;
            r_sqv <= 1'b0;
            r_ztail <= 1'b0;
            r_mv <= 1'b0;
            r_bv <= 1'b0;
            r_ispair <= 1'b0;
            r_rdq <= 1'b0;
            o_done <= 1'b0;
            r_zlast <= 1'b0;
        end else begin
            r_ph <= n_ph;
            r_cnt <= n_cnt;
            o_done <= 1'b0;
            // Pair pipeline: A read, B read, B arrives, products, write A, write B.
            r_ispair <= (r_ph == P_RDB);
            r_bv <= (r_ph == P_CALC) && r_ispair;
            r_mv <= r_bv;
            if (r_ph == P_RDB) begin
                r_ar <= r_rdata[CompW-1:0];
                r_ai <= r_rdata[2*CompW-1:CompW];
            end
            if (r_ph == P_CALC && r_ispair) begin
                r_br <= r_rdata[CompW-1:0];
                r_bi <= r_rdata[2*CompW-1:CompW];
            end
            r_m0 <= m0; r_m1 <= m1; r_m2 <= m2; r_m3 <= m3;
            r_m4 <= m4; r_m5 <= m5; r_m6 <= m6; r_m7 <= m7;
            // Z sweep: read, square, accumulate.
            r_zv <= (r_ph == P_ZRD) || (r_ph == P_RD1);
            r_rdq <= (r_ph == P_RD1);
            r_zlast <= (r_ph == P_ZRD) && (n_ph == P_IDLE);
            r_zidx <= raddr;
            if (r_ph == P_IDLE && i_ctl.start_z) r_acc <= '0;
            r_sqv <= r_zv;
            r_ztail <= r_sqv && r_zlast_q;
            if (r_zv) begin
                r_sq <= (2*CompW)'(sqr + sqi);
                r_zsel <= r_rdq;
                r_zneg <= (r_zidx & tmask) != '0;
                r_zlast_q <= r_zlast;
                if (r_rdq) begin
                    o_are <= pr; o_aim <= pi;
                end
            end
            if (r_sqv) begin
                if (r_zsel) o_meas <= prob[CompW-1:0];
                else r_acc <= r_zneg ? r_acc - prob : r_acc + prob;
            end
            if (r_ztail) o_done <= 1'b1;
        end
    end

    assign o_z = sat_comp(r_acc);
endmodule

FILE: src/state_vector_gate_engine.sv
// Top level of the state vector gate engine.
`timescale 1ns / 1ps
// A store of 1024 complex Q2.16 amplitudes in one single-port-read memory.
// After reset the block clears the store before it takes the first request.
// Each gate sweeps the 2^(n-1) amplitude pairs, each pair by two reads, a
// step for B to arrive, a step for the products and two writes, then sweeps
// all 2^n entries once more for the Z expectation. CNOT and CZ step past each
// pair whose control bit is clear without reading or writing it. A read and
// a ground reset also end with a Z sweep of all 2^n entries, and a ground
// reset first clears the whole store. Errored requests are answered without
// a sweep. One result goes out per request; the output register holds it
// until taken.
module state_vector_gate_engine import svge_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[3:0], target_qubit[7:4], control_qubit[11:8], cos_term[29:12],
    // sin_term[47:30], amp_index[57:48], zero fill
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], amp_real[19:2], amp_imag[37:20], measure_value[55:38],
    // z_expectation[73:56], zero fill
    output logic [79:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);
    logic [3:0] r_nq;
    t_ctl ctl;
    t_cmd cmd;
    t_sts sts;
    logic err, done;
    logic [1:0] err_code;
    t_comp are, aim, meas, z;
    logic r_ov;
    logic [79:0] r_od;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_nq <= 4'd10;
        else if (i_cfg_valid) r_nq <= i_cfg_data;
    end

    svge_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_func(s_axis_tdata[3:0]), .i_tq(s_axis_tdata[7:4]),
        .i_cq(s_axis_tdata[11:8]), .i_idx(s_axis_tdata[57:48]),
        .i_nq(r_nq), .i_out_free(!r_ov && !sts.busy),
        .o_ctl(ctl), .o_cmd(cmd), .o_err(err), .o_err_code(err_code),
        .i_sts(sts)
    );

    logic [AddrW-1:0] r_idx;
    t_comp r_cos, r_sin;
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_idx <= s_axis_tdata[57:48];
            r_cos <= s_axis_tdata[29:12];
            r_sin <= s_axis_tdata[47:30];
        end
    end

    svge_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_ctl(ctl), .i_cmd(cmd), .i_idx(r_idx),
        .i_cos(r_cos), .i_sin(r_sin),
        .o_sts(sts), .o_done(done),
        .o_are(are), .o_aim(aim), .o_meas(meas), .o_z(z)
    );

    // A target outside the simulated qubits gives no expectation.
    logic zok;
    assign zok = (cmd.dim >> cmd.tq) > (AddrW+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_ov <= 1'b0;
            if (err) begin
                r_ov <= 1'b1;
                r_od <= {78'd0, err_code};
            end else if (done) begin
                r_ov <= 1'b1;
                r_od <= {6'd0,
                    zok ? z : t_comp'(0),
                    (cmd.func == FUNC_READ) ? meas :
                        ((cmd.func == FUNC_Z) ? z : t_comp'(0)),
                    (cmd.func == FUNC_READ) ? aim : t_comp'(0),
                    (cmd.func == FUNC_READ) ? are : t_comp'(0),
                    ST_OK};
            end
        end
    end
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_od;
endmodule
